// ===== rtl/pcx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared constants, types and tables for the complex pixel component
// extractor: cordic datapath widths, angle table and result kind codes.
// ----------------------------------------------------------------------------
package pcx_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int SAMPLE_BITS   = 16;

    localparam int MAX_STAGES  = 24;
    localparam int N_STAGES    = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int SHIFT_W     = 5;
    localparam int IN_W        = 16;
    localparam int SAMPLE_EFF  = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
    localparam int GUARD_SHIFT = 4;
    localparam int XW          = 23;
    localparam int ZW          = 34;
    localparam int GAIN_W      = 31;
    localparam int PW          = XW + GAIN_W;
    localparam int VW          = 17;
    localparam int MASK_W      = 5;
    localparam int KIND_W      = 3;

    localparam logic signed [GAIN_W-1:0] INV_GAIN_Q30 = 31'sd652032874;
    localparam logic signed [ZW-1:0]     Z_HALF_PI    = 34'sd1073741824;

    localparam logic signed [VW-1:0] VAL_MAX   = 17'sd65535;
    localparam logic signed [VW-1:0] VAL_MIN   = -17'sd65536;
    localparam logic signed [VW-1:0] PH_ZERO   = 17'sd0;
    localparam logic signed [VW-1:0] PH_PI     = 17'sd32768;
    localparam logic signed [VW-1:0] PH_HALF   = 17'sd16384;
    localparam logic signed [VW-1:0] PH_M_HALF = -17'sd16384;

    localparam logic [KIND_W-1:0] KIND_MAG    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REAL   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_IMAG   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PHASE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TPHASE = 3'd4;

    localparam logic [MASK_W-1:0] MASK_RESET = 5'd1;

    // one item travelling down the cordic chain
    typedef struct packed {
        logic signed [XW-1:0]   x;
        logic signed [XW-1:0]   y;
        logic signed [ZW-1:0]   z;
        logic signed [IN_W-1:0] re;
        logic signed [IN_W-1:0] im;
        logic                   img;
    } t_cdata;

    // finished pixel handed to the serializer
    typedef struct packed {
        logic signed [VW-1:0] mag;
        logic signed [VW-1:0] re;
        logic signed [VW-1:0] im;
        logic signed [VW-1:0] ph;
        logic                 img;
    } t_pix;

    typedef struct packed {
        logic can_load;
        logic busy;
    } t_ser_stat;

    // atan(2^-i), pi = 2^31
    function automatic logic signed [ZW-1:0] atan_lut(input logic [SHIFT_W-1:0] idx);
        logic signed [ZW-1:0] r;
        begin
            case (idx)
                5'd0:    r = 34'sd536870912;
                5'd1:    r = 34'sd316933406;
                5'd2:    r = 34'sd167458907;
                5'd3:    r = 34'sd85004756;
                5'd4:    r = 34'sd42667331;
                5'd5:    r = 34'sd21354465;
                5'd6:    r = 34'sd10680862;
                5'd7:    r = 34'sd5340245;
                5'd8:    r = 34'sd2670163;
                5'd9:    r = 34'sd1335087;
                5'd10:   r = 34'sd667544;
                5'd11:   r = 34'sd333772;
                5'd12:   r = 34'sd166886;
                5'd13:   r = 34'sd83443;
                5'd14:   r = 34'sd41722;
                5'd15:   r = 34'sd20861;
                5'd16:   r = 34'sd10430;
                5'd17:   r = 34'sd5215;
                5'd18:   r = 34'sd2608;
                5'd19:   r = 34'sd1304;
                5'd20:   r = 34'sd652;
                5'd21:   r = 34'sd326;
                5'd22:   r = 34'sd163;
                5'd23:   r = 34'sd81;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // sign extend from the configured sample width
    function automatic logic signed [IN_W-1:0] sample_ext(input logic [IN_W-1:0] v);
        logic [IN_W-1:0] r;
        begin
            for (int i = 0; i < IN_W; i++) begin
                r[i] = (i < SAMPLE_EFF) ? v[i] : v[SAMPLE_EFF-1];
            end
            return $signed(r);
        end
    endfunction

endpackage

// ===== rtl/complex_pixel_component_extract_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_pixel_component_extract_top
// Splits each complex pixel into the components chosen by the mask:
// magnitude and phase from a pipelined vectoring cordic, real and imaginary
// passed through, one tagged item per component.
// ----------------------------------------------------------------------------
// path: a pixel passes through the pre-rotation register, one register per
//   cordic cell, the gain multiply register and the serializer register
// throughput: one pixel per cycle with one mask bit set while m_axis_tready
//   is high; the serializer emits one item per cycle while m_axis_tready is
//   high, one item per set mask bit
// reset: synchronous active low, clears all valid state, mask resets to 1
module complex_pixel_component_extract_top
    import pcx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MASK_W-1:0] i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // [15:0] real_part, [31:16] imag_part
    input  logic              s_axis_tlast,   // image_end
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // [16:0] component_value
    output logic [3:0]        m_axis_tuser,   // [2:0] component_kind, [3] image_done
    output logic              m_axis_tlast    // pixel_done
);

    logic [MASK_W-1:0] r_mask;
    logic              en;
    t_ser_stat         ser_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RESET;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    // ---------------- pre-rotation into the right half plane
    logic signed [IN_W-1:0] s_re;
    logic signed [IN_W-1:0] s_im;
    logic signed [XW-1:0]   gx;
    logic signed [XW-1:0]   gy;
    t_cdata                 n_pre;

    always_comb begin
        s_re        = sample_ext(s_axis_tdata[15:0]);
        s_im        = sample_ext(s_axis_tdata[31:16]);
        gx          = {{(XW-IN_W-GUARD_SHIFT){s_re[IN_W-1]}}, s_re, {GUARD_SHIFT{1'b0}}};
        gy          = {{(XW-IN_W-GUARD_SHIFT){s_im[IN_W-1]}}, s_im, {GUARD_SHIFT{1'b0}}};
        n_pre.re    = s_re;
        n_pre.im    = s_im;
        n_pre.img   = s_axis_tlast;
        n_pre.x     = gx;
        n_pre.y     = gy;
        n_pre.z     = '0;
        if (gx < 0) begin
            if (gy >= 0) begin
                n_pre.x = gy;
                n_pre.y = -gx;
                n_pre.z = Z_HALF_PI;
            end else begin
                n_pre.x = -gy;
                n_pre.y = gx;
                n_pre.z = -Z_HALF_PI;
            end
        end
    end

    logic   c_valid [0:N_STAGES];
    t_cdata c_data  [0:N_STAGES];
    logic   r_p_valid;
    t_cdata r_p_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_data <= n_pre;
        end
    end

    assign c_valid[0] = r_p_valid;
    assign c_data[0]  = r_p_data;

    // ---------------- chain of micro-rotation cells
    for (genvar i = 0; i < N_STAGES; i++) begin : g_cell
        pcx_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_shift (SHIFT_W'(i)),
            .i_valid (c_valid[i]),
            .i_data  (c_data[i]),
            .o_valid (c_valid[i+1]),
            .o_data  (c_data[i+1])
        );
    end

    // ---------------- gain correction multiply and phase rounding
    t_cdata                 last_c;
    logic signed [PW-1:0]   m_prod;
    logic signed [ZW:0]     z_rnd;
    logic signed [ZW-16:0]  z_sh;
    logic signed [VW-1:0]   n_ph;

    always_comb begin
        last_c = c_data[N_STAGES];
        m_prod = $signed(last_c.x) * INV_GAIN_Q30;
        z_rnd  = $signed({last_c.z[ZW-1], last_c.z}) + (ZW+1)'(32768);
        z_sh   = z_rnd[ZW:16];
        if (z_sh > $signed((ZW-15)'(32768))) begin
            n_ph = PH_PI;
        end else if (z_sh < -$signed((ZW-15)'(32768))) begin
            n_ph = -PH_PI;
        end else begin
            n_ph = z_sh[VW-1:0];
        end
    end

    logic                   r_m_valid;
    logic signed [PW-1:0]   r_m_prod;
    logic signed [VW-1:0]   r_m_ph;
    logic signed [IN_W-1:0] r_m_re;
    logic signed [IN_W-1:0] r_m_im;
    logic                   r_m_img;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= c_valid[N_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_prod <= m_prod;
            r_m_ph   <= n_ph;
            r_m_re   <= last_c.re;
            r_m_im   <= last_c.im;
            r_m_img  <= last_c.img;
        end
    end

    // ---------------- magnitude rounding and axis special cases
    logic signed [PW-1:0]    mag_rnd;
    logic signed [PW-35:0]   mag_sh;
    logic signed [VW-1:0]    re_x;
    logic signed [VW-1:0]    im_x;
    t_pix                    pix;

    always_comb begin
        mag_rnd = r_m_prod + (PW'(1) <<< 33);
        mag_sh  = mag_rnd[PW-1:34];
        re_x    = VW'(r_m_re);
        im_x    = VW'(r_m_im);
        pix.re  = re_x;
        pix.im  = im_x;
        pix.img = r_m_img;
        pix.ph  = r_m_ph;
        if (mag_sh > $signed((PW-34)'(VAL_MAX))) begin
            pix.mag = VAL_MAX;
        end else if (mag_sh < $signed((PW-34)'(VAL_MIN))) begin
            pix.mag = VAL_MIN;
        end else begin
            pix.mag = mag_sh[VW-1:0];
        end
        if (r_m_re == '0 && r_m_im == '0) begin
            pix.mag = '0;
            pix.ph  = PH_ZERO;
        end else if (r_m_im == '0) begin
            pix.mag = (re_x < 0) ? -re_x : re_x;
            pix.ph  = (re_x > 0) ? PH_ZERO : PH_PI;
        end else if (r_m_re == '0) begin
            pix.mag = (im_x < 0) ? -im_x : im_x;
            pix.ph  = (im_x > 0) ? PH_HALF : PH_M_HALF;
        end
    end

    assign en            = !r_m_valid || ser_stat.can_load;
    assign s_axis_tready = en;

    pcx_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_m_valid),
        .i_pix        (pix),
        .i_mask       (r_mask),
        .o_stat       (ser_stat),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata),
        .o_tuser      (m_axis_tuser),
        .o_tlast      (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // intake only stalls while a pixel is still being emitted
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> ser_stat.busy && !(m_axis_tready && m_axis_tlast))
        else $error("intake stalled without pending output");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] == KIND_PHASE || m_axis_tuser[2:0] == KIND_TPHASE)
        |-> $signed(m_axis_tdata[16:0]) <= PH_PI && $signed(m_axis_tdata[16:0]) >= -PH_PI)
        else $error("phase out of range");

    a_mag_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:0] == KIND_MAG |-> !m_axis_tdata[16])
        else $error("negative magnitude");

    a_emit_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && ser_stat.can_load && r_mask != '0 |=> ser_stat.busy)
        else $error("loaded pixel with components produced no item");
`endif

endmodule

// ===== rtl/pcx_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_cordic_cell
// One vectoring micro-rotation: rotates x/y toward the x axis by atan(2^-s)
// and accumulates the angle, registered, handing the item to the next cell.
// ----------------------------------------------------------------------------
module pcx_cordic_cell
    import pcx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [SHIFT_W-1:0] i_shift,
    input  logic               i_valid,
    input  t_cdata             i_data,
    output logic               o_valid,
    output t_cdata             o_data
);

    logic   r_valid;
    t_cdata r_data;
    t_cdata n_data;

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] ang;

    always_comb begin
        dx     = $signed(i_data.y) >>> i_shift;
        dy     = $signed(i_data.x) >>> i_shift;
        ang    = atan_lut(i_shift);
        n_data = i_data;
        if (!i_data.y[XW-1]) begin
            n_data.x = $signed(i_data.x) + dx;
            n_data.y = $signed(i_data.y) - dy;
            n_data.z = $signed(i_data.z) + ang;
        end else begin
            n_data.x = $signed(i_data.x) - dx;
            n_data.y = $signed(i_data.y) + dy;
            n_data.z = $signed(i_data.z) - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/pcx_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_serializer
// Holds one finished pixel and emits one item per selected component,
// lowest mask bit first, flagging the last one of the pixel.
// ----------------------------------------------------------------------------
module pcx_serializer
    import pcx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load_valid,
    input  t_pix              i_pix,
    input  logic [MASK_W-1:0] i_mask,
    output t_ser_stat         o_stat,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [23:0]       o_tdata,   // [16:0] component_value
    output logic [3:0]        o_tuser,   // [2:0] component_kind, [3] image_done
    output logic              o_tlast    // pixel_done
);

    logic [MASK_W-1:0] r_rem;
    logic [MASK_W-1:0] n_rem;
    t_pix              r_pix;

    logic [MASK_W-1:0]    lsb;
    logic [MASK_W-1:0]    rest;
    logic [KIND_W-1:0]    kind;
    logic signed [VW-1:0] val;
    logic                 last;
    logic                 can_load;

    always_comb begin
        lsb  = r_rem & (~r_rem + MASK_W'(1));
        rest = r_rem & ~lsb;
        last = (rest == '0);
        case (lsb)
            5'b00001: kind = KIND_MAG;
            5'b00010: kind = KIND_REAL;
            5'b00100: kind = KIND_IMAG;
            5'b01000: kind = KIND_PHASE;
            5'b10000: kind = KIND_TPHASE;
            default:  kind = KIND_MAG;
        endcase
        case (kind)
            KIND_MAG:  val = r_pix.mag;
            KIND_REAL: val = r_pix.re;
            KIND_IMAG: val = r_pix.im;
            default:   val = r_pix.ph;
        endcase
        can_load = (r_rem == '0) || (i_tready && last);
        n_rem    = r_rem;
        if (can_load && i_load_valid) begin
            n_rem = i_mask;
        end else if (r_rem != '0 && i_tready) begin
            n_rem = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load && i_load_valid) begin
            r_pix <= i_pix;
        end
    end

    assign o_stat.can_load = can_load;
    assign o_stat.busy     = (r_rem != '0);
    assign o_tvalid        = (r_rem != '0);
    assign o_tdata         = {7'b0, val};
    assign o_tuser         = {r_pix.img, kind};
    assign o_tlast         = last;

endmodule
